>>> src/ail_pkg.sv
// Shared types and constants of the lease-based identifier allocator.
// Used by ail_ctrl, ail_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ail_pkg;

    localparam int ID_W   = 16;
    localparam int TIME_W = 40;
    localparam int LEASE_W = 32;
    localparam int CNT32_W = 32;
    localparam int THR_W  = 20;
    localparam int POL_W  = 40;
    localparam int CIDX_W = 3;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [CNT32_W-1:0] COUNT_MAX = {CNT32_W{1'b1}};
    localparam logic [11:0]        SEC_PER_HOUR = 12'd3600;
    localparam logic [8:0]         Q8_ONE = 9'd256;

    localparam logic [ID_W-1:0]    RST_FIRST_ID  = 16'd0;
    localparam logic [ID_W-1:0]    RST_LAST_ID   = 16'd255;
    localparam logic [LEASE_W-1:0] RST_DEFAULT   = 32'd86400;
    localparam logic [LEASE_W-1:0] RST_MIN       = 32'd60;
    localparam logic [LEASE_W-1:0] RST_MAX       = 32'd86400;
    localparam logic [LEASE_W-1:0] RST_WINDOW    = 32'd3600;
    localparam logic [THR_W-1:0]   RST_THRESHOLD = 20'd60;
    localparam logic [POL_W-1:0]   RST_POLICY    = 40'd68753241191;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FIRST_ID  = 3'd0,
        CFG_LAST_ID   = 3'd1,
        CFG_DEFAULT   = 3'd2,
        CFG_MIN       = 3'd3,
        CFG_MAX       = 3'd4,
        CFG_WINDOW    = 3'd5,
        CFG_THRESHOLD = 3'd6,
        CFG_POLICY    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_TOUCH   = 2'd2,
        ACT_CLEAN   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PURGE,
        S_WIN,
        S_RATE,
        S_MUL1,
        S_MUL2,
        S_CLAMP,
        S_SEARCH0,
        S_SEARCH,
        S_SEARCH_CHK,
        S_GRANT,
        S_FIND,
        S_FIND_CHK,
        S_TOUCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic pass_start;
        logic purge_en;
        logic search_en;
        logic find_en;
        logic lease_def;
        logic win_upd;
        logic rate_mul;
        logic lease_m1;
        logic lease_m2;
        logic lease_clamp;
        logic cand_init;
        logic grant;
        logic release_slot;
        logic touch_mul;
        logic touch_wr;
        logic set_ok;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_action act;
        logic    pool_empty;
        logic    adaptive;
        logic    pass_last;
        logic    hit;
        logic    cand_over;
        logic    free_found;
        logic    match;
        logic    out_free;
    } t_status;

endpackage
`default_nettype wire

>>> src/ail_ctrl.sv
// Controller state machine of the allocator: sequences passes and arithmetic steps.
// Depends on ail_pkg; drives ail_dp through t_cmd and reads t_status.
`timescale 1ns / 1ps
`default_nettype none
module ail_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ail_pkg::t_status i_status,
    output ail_pkg::t_cmd        o_cmd,
    output logic                 o_idle
);
    import ail_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.act)
                    ACT_ALLOC: begin
                        if (i_status.pool_empty) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.pass_start = 1'b1;
                            n_state = S_PURGE;
                        end
                    end
                    ACT_CLEAN: begin
                        o_cmd.pass_start = 1'b1;
                        n_state = S_PURGE;
                    end
                    default: begin
                        o_cmd.pass_start = 1'b1;
                        n_state = S_FIND;
                    end
                endcase
            end
            S_PURGE: begin
                o_cmd.purge_en = 1'b1;
                if (i_status.pass_last) begin
                    if (i_status.act == ACT_CLEAN) begin
                        o_cmd.set_ok = 1'b1;
                        n_state = S_DONE;
                    end else if (i_status.adaptive) begin
                        n_state = S_WIN;
                    end else begin
                        o_cmd.lease_def = 1'b1;
                        n_state = S_SEARCH0;
                    end
                end
            end
            S_WIN: begin
                o_cmd.win_upd = 1'b1;
                n_state = S_RATE;
            end
            S_RATE: begin
                o_cmd.rate_mul = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.lease_m1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.lease_m2 = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.lease_clamp = 1'b1;
                n_state = S_SEARCH0;
            end
            S_SEARCH0: begin
                if (!i_status.free_found) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.cand_init  = 1'b1;
                    o_cmd.pass_start = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search_en = 1'b1;
                if (i_status.pass_last) begin
                    n_state = S_SEARCH_CHK;
                end
            end
            S_SEARCH_CHK: begin
                if (i_status.cand_over) begin
                    n_state = S_DONE;
                end else if (i_status.hit) begin
                    o_cmd.pass_start = 1'b1;
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_GRANT;
                end
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state = S_DONE;
            end
            S_FIND: begin
                o_cmd.find_en = 1'b1;
                if (i_status.pass_last) begin
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (!i_status.match) begin
                    n_state = S_DONE;
                end else if (i_status.act == ACT_RELEASE) begin
                    o_cmd.release_slot = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.touch_mul = 1'b1;
                    n_state = S_TOUCH;
                end
            end
            S_TOUCH: begin
                o_cmd.touch_wr = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/ail_dp.sv
// Datapath of the allocator: configuration, lease table memory, valid bits,
// rate window, lease arithmetic and result register. Depends on ail_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ail_dp #(
    parameter int ENTRIES = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ail_pkg::t_cmd             i_cmd,
    output ail_pkg::t_status               o_status,
    input  wire logic                      i_in_valid,
    input  wire logic [1:0]                i_action,
    input  wire logic [ail_pkg::ID_W-1:0]  i_req_id,
    input  wire logic [ail_pkg::TIME_W-1:0] i_now,
    input  wire logic                      i_cfg_we,
    input  wire logic [ail_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic [ail_pkg::POL_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_out_ok,
    output logic [ail_pkg::ID_W-1:0]       o_out_granted_id,
    output logic [ail_pkg::TIME_W-1:0]     o_out_lease_end
);
    import ail_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HELD_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } t_slot;

    // configuration
    logic [ID_W-1:0]    r_first, r_last;
    logic [LEASE_W-1:0] r_default, r_min, r_max, r_window;
    logic [THR_W-1:0]   r_thr;
    logic [POL_W-1:0]   r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= RST_FIRST_ID;
            r_last    <= RST_LAST_ID;
            r_default <= RST_DEFAULT;
            r_min     <= RST_MIN;
            r_max     <= RST_MAX;
            r_window  <= RST_WINDOW;
            r_thr     <= RST_THRESHOLD;
            r_policy  <= RST_POLICY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FIRST_ID:  r_first   <= i_cfg_data[ID_W-1:0];
                CFG_LAST_ID:   r_last    <= i_cfg_data[ID_W-1:0];
                CFG_DEFAULT:   r_default <= i_cfg_data[LEASE_W-1:0];
                CFG_MIN:       r_min     <= i_cfg_data[LEASE_W-1:0];
                CFG_MAX:       r_max     <= i_cfg_data[LEASE_W-1:0];
                CFG_WINDOW:    r_window  <= i_cfg_data[LEASE_W-1:0];
                CFG_THRESHOLD: r_thr     <= i_cfg_data[THR_W-1:0];
                CFG_POLICY:    r_policy  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [8:0]  rate_f, wmark, press_f;
    logic [11:0] touch_f;
    assign rate_f  = r_policy[9:1];
    assign wmark   = r_policy[18:10];
    assign press_f = r_policy[27:19];
    assign touch_f = r_policy[39:28];

    // latched item
    t_action         r_act;
    logic [ID_W-1:0] r_req;
    logic [TIME_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act <= t_action'(i_action);
            r_req <= i_req_id;
            r_now <= i_now;
        end
    end

    // table scan
    t_slot mem [ENTRIES];
    t_slot r_rd;
    logic [ENTRIES-1:0] r_valid;
    logic              r_issue, r_ev;
    logic [IDX_W-1:0]  r_idx, r_ev_idx;
    logic              pass_last;

    assign pass_last = r_ev && (r_ev_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_ev    <= 1'b0;
        end else if (i_cmd.pass_start) begin
            r_issue <= 1'b1;
            r_ev    <= 1'b0;
        end else begin
            r_ev <= r_issue;
            if (r_issue && r_idx == LAST_IDX) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_start) begin
            r_idx <= '0;
        end else if (r_issue && r_idx != LAST_IDX) begin
            r_idx <= r_idx + 1'b1;
        end
        r_ev_idx <= r_idx;
    end

    // lease registers
    logic [HELD_W-1:0]  r_held;
    logic               r_free_found, r_hit, r_match;
    logic [IDX_W-1:0]   r_free_idx, r_match_idx;
    logic [ID_W:0]      r_cand;
    logic [TIME_W-1:0]  r_wstart;
    logic [CNT32_W-1:0] r_wcount;
    logic [LEASE_W-1:0] r_elapsed;
    logic [43:0]        r_cnt_p;
    logic [51:0]        r_thr_p;
    logic [8:0]         r_pf;
    logic [40:0]        r_m1;
    logic [35:0]        r_m2;
    logic [LEASE_W-1:0] r_lease;
    logic               r_res_ok;
    logic [ID_W-1:0]    r_res_gid;
    logic [TIME_W-1:0]  r_res_end;

    logic              cur_valid, expired, keep;
    logic [TIME_W:0]   win_end;
    logic [TIME_W-1:0] ws_eff;
    logic [LEASE_W-1:0] clamped;
    logic [TIME_W-1:0] new_end;
    logic [ID_W:0]     cap;

    function automatic logic [LEASE_W-1:0] clamp_lease(
        input logic [35:0]        v,
        input logic [LEASE_W-1:0] lo,
        input logic [LEASE_W-1:0] hi
    );
        logic [35:0] t;
        t = (v < {4'd0, lo}) ? {4'd0, lo} : v;
        if (t > {4'd0, hi}) begin
            t = {4'd0, hi};
        end
        return t[LEASE_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_add(
        input logic [TIME_W-1:0]  a,
        input logic [LEASE_W-1:0] b
    );
        logic [TIME_W:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    assign cur_valid = r_valid[r_ev_idx];
    assign expired   = r_now > r_rd.expiry;
    assign keep      = cur_valid && !expired;
    assign ws_eff    = (r_wstart == '0) ? r_now : r_wstart;
    assign win_end   = {1'b0, ws_eff} + {9'd0, r_window};
    assign clamped   = clamp_lease(r_m2, r_min, r_max);
    assign new_end   = sat_add(r_now, (r_act == ACT_TOUCH) ? clamped : r_lease);
    assign cap       = {1'b0, r_last} - {1'b0, r_first} + 1'b1;

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_idx];
        if (i_cmd.grant) begin
            mem[r_free_idx] <= '{id: r_cand[ID_W-1:0], expiry: new_end};
        end else if (i_cmd.touch_wr) begin
            mem[r_match_idx] <= '{id: r_req, expiry: new_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.purge_en && r_ev && cur_valid && expired) begin
            r_valid[r_ev_idx] <= 1'b0;
        end else if (i_cmd.grant) begin
            r_valid[r_free_idx] <= 1'b1;
        end else if (i_cmd.release_slot) begin
            r_valid[r_match_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_start) begin
            r_hit   <= 1'b0;
            r_match <= 1'b0;
        end
        if (i_cmd.pass_start && (i_cmd.purge_en || !i_cmd.cand_init)
            && r_act != ACT_ALLOC) begin
            r_free_found <= 1'b0;
        end
        if (i_cmd.latch) begin
            r_held       <= '0;
            r_free_found <= 1'b0;
        end
        if (i_cmd.purge_en && r_ev) begin
            r_held <= r_held + HELD_W'(keep);
            if (!keep && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_ev_idx;
            end
        end
        if (i_cmd.cand_init) begin
            r_cand <= {1'b0, r_first};
        end else if (i_cmd.search_en && r_ev && cur_valid
                     && {1'b0, r_rd.id} == r_cand) begin
            r_cand <= r_cand + 1'b1;
            r_hit  <= 1'b1;
        end
        if (i_cmd.find_en && r_ev && cur_valid && r_rd.id == r_req && !r_match) begin
            r_match     <= 1'b1;
            r_match_idx <= r_ev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= '0;
            r_wcount <= '0;
        end else if (i_cmd.win_upd) begin
            if ({1'b0, r_now} > win_end) begin
                r_wstart <= r_now;
                r_wcount <= '0;
            end else begin
                r_wstart <= ws_eff;
            end
        end else if (i_cmd.grant && r_wcount != COUNT_MAX) begin
            r_wcount <= r_wcount + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_upd) begin
            if ({1'b0, r_now} > win_end) begin
                r_elapsed <= LEASE_W'(1);
            end else if (r_now > ws_eff) begin
                r_elapsed <= LEASE_W'(r_now - ws_eff);
            end else begin
                r_elapsed <= LEASE_W'(1);
            end
        end
        if (i_cmd.rate_mul) begin
            r_cnt_p <= 44'(r_wcount) * 44'(SEC_PER_HOUR);
            r_thr_p <= 52'(r_thr) * 52'(r_elapsed);
            r_pf    <= ({18'd0, r_held, 8'd0} >= {8'd0, 26'(wmark) * 26'(cap)})
                       ? press_f : Q8_ONE;
        end
        if (i_cmd.lease_m1) begin
            r_m1 <= 41'(r_default) * 41'((r_cnt_p >= {8'd0, r_thr_p[43:0]}
                    && r_thr_p[51:44] == '0) ? rate_f : Q8_ONE);
        end
        if (i_cmd.lease_m2) begin
            r_m2 <= 36'((50'(r_m1) * 50'(r_pf)) >> 16);
        end
        if (i_cmd.touch_mul) begin
            r_m2 <= 36'((44'(r_default) * 44'(touch_f)) >> 8);
        end
        if (i_cmd.lease_clamp) begin
            r_lease <= clamped;
        end else if (i_cmd.lease_def) begin
            r_lease <= r_default;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_res_ok  <= 1'b0;
            r_res_gid <= '0;
            r_res_end <= '0;
        end else if (i_cmd.grant) begin
            r_res_ok  <= 1'b1;
            r_res_gid <= r_cand[ID_W-1:0];
            r_res_end <= new_end;
        end else if (i_cmd.touch_wr) begin
            r_res_ok  <= 1'b1;
            r_res_end <= new_end;
        end else if (i_cmd.release_slot || i_cmd.set_ok) begin
            r_res_ok  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_ok         <= r_res_ok;
            o_out_granted_id <= r_res_gid;
            o_out_lease_end  <= r_res_end;
        end
    end

    always_comb begin
        o_status.in_valid   = i_in_valid;
        o_status.act        = r_act;
        o_status.pool_empty = r_last < r_first;
        o_status.adaptive   = r_policy[0];
        o_status.pass_last  = pass_last;
        o_status.hit        = r_hit;
        o_status.cand_over  = r_cand > {1'b0, r_last};
        o_status.free_found = r_free_found;
        o_status.match      = r_match;
        o_status.out_free   = !o_out_valid || !i_out_stall;
    end

endmodule
`default_nettype wire

>>> src/adaptive_id_lease_allocator.sv
// Top level of the lease-based identifier pool allocator.
// Depends on ail_pkg, ail_ctrl and ail_dp.
//
// Input channel: i_in_valid / o_in_stall with action, req_id and now.
// Output channel: o_out_valid / i_out_stall with ok, granted_id and lease_end;
// every input beat gives exactly one output beat, in order.
// Configuration: i_cfg_valid / o_cfg_ready with a 3-bit register index and
// 40-bit data; ready is always high. Write only while the block is idle.
// The block works on one item at a time; o_in_stall is high while busy.
// Each table pass reads the lease memory one entry a cycle.
// Steps from input beat to result: cleanup runs a purge pass; release and
// touch a find pass, a touch of a known id then a multiply and a write;
// an empty pool none. Allocate: a purge pass, the lease arithmetic (window,
// rate, lease multiplies, clamp) when adaptive, then k search passes and the
// grant; k is 1 when the lowest id is free, one more per pass finding held ids; at most ENTRIES + 1.
// The next input beat is accepted in the cycle after the result is loaded.
// The result sits in an output register and holds while stalled; the block
// waits in its final state only while that register is still full and stalled.
// Reset clears all leases and the rate window and restores the defaults.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_id_lease_allocator #(
    parameter int ENTRIES = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_action,
    input  wire logic [ail_pkg::ID_W-1:0]   i_req_id,
    input  wire logic [ail_pkg::TIME_W-1:0] i_now,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_ok,
    output logic [ail_pkg::ID_W-1:0]        o_granted_id,
    output logic [ail_pkg::TIME_W-1:0]      o_lease_end,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [ail_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic [ail_pkg::POL_W-1:0]  i_cfg_data
);
    import ail_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    idle;

    assign o_in_stall  = !idle;
    assign o_cfg_ready = 1'b1;

    ail_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    ail_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_in_valid       (i_in_valid),
        .i_action         (i_action),
        .i_req_id         (i_req_id),
        .i_now            (i_now),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_ok         (o_ok),
        .o_out_granted_id (o_granted_id),
        .o_out_lease_end  (o_lease_end)
    );

endmodule
`default_nettype wire

>>> src/ail_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module ail_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_ok,
    input wire logic [15:0] o_granted_id,
    input wire logic [39:0] o_lease_end
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_ok) && $stable(o_granted_id)
            && $stable(o_lease_end))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_granted_id == 16'd0 && o_lease_end == 40'd0)
        else $error("failed result carries data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat accepted while busy");

endmodule

bind adaptive_id_lease_allocator ail_checker u_ail_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_ok         (o_ok),
    .o_granted_id (o_granted_id),
    .o_lease_end  (o_lease_end)
);
`default_nettype wire

>>> verif/tb_adaptive_id_lease_allocator.sv
// Self-checking testbench for the adaptive lease-based identifier allocator.
// Drives lease requests and register writes, predicts each result in place.
// Depends on ail_pkg and adaptive_id_lease_allocator.
`timescale 1ns / 1ps
module tb_adaptive_id_lease_allocator;
    import ail_pkg::*;

    localparam int ENT = 64;
    localparam int WATCH_LIMIT = 60000;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   gid;
        logic [TIME_W-1:0] lend;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_action;
    logic [ID_W-1:0]   i_req_id;
    logic [TIME_W-1:0] i_now;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_ok;
    logic [ID_W-1:0]   o_granted_id;
    logic [TIME_W-1:0] o_lease_end;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [POL_W-1:0]  i_cfg_data;

    adaptive_id_lease_allocator #(.ENTRIES(ENT)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] m_first, m_last, m_def, m_min, m_max, m_win, m_thr, m_pol;
    logic        m_valid [ENT];
    logic [15:0] m_id    [ENT];
    logic [63:0] m_exp   [ENT];
    logic [63:0] m_wstart, m_wcount;

    t_reply      pending_replies[$];
    int          errors = 0;
    int          items_sent = 0;
    int          grants = 0;
    int          cfg_writes = 0;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    logic [39:0] clock_now = 40'd1000;

    function automatic logic [63:0] clamp_len(logic [63:0] v);
        if (v < m_min) v = m_min;
        if (v > m_max) v = m_max;
        return v;
    endfunction

    function automatic logic [63:0] sat_end(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
    endfunction

    function automatic void expire_leases(logic [63:0] t);
        for (int i = 0; i < ENT; i++)
            if (m_valid[i] && t > m_exp[i]) m_valid[i] = 1'b0;
    endfunction

    function automatic int slot_of(logic [15:0] id);
        for (int i = 0; i < ENT; i++)
            if (m_valid[i] && m_id[i] == id) return i;
        return -1;
    endfunction

    function automatic logic [63:0] grant_length(logic [63:0] t);
        logic [63:0] rf, wm, pf, elapsed, held, cap, r, p;
        rf = (m_pol >> 1) & 64'h1FF;
        wm = (m_pol >> 10) & 64'h1FF;
        pf = (m_pol >> 19) & 64'h1FF;
        held = 0;
        r = 256;
        p = 256;
        if (m_pol[0] == 1'b0) return m_def;
        if (m_wstart == 0) m_wstart = t;
        if (t > m_wstart + m_win) begin
            m_wstart = t;
            m_wcount = 0;
        end
        elapsed = (t > m_wstart) ? t - m_wstart : 64'd1;
        if (m_wcount * 64'd3600 >= m_thr * elapsed) r = rf;
        for (int i = 0; i < ENT; i++)
            if (m_valid[i]) held++;
        cap = (m_last >= m_first) ? m_last - m_first + 1 : 64'd0;
        if (held * 64'd256 >= wm * cap) p = pf;
        return clamp_len((m_def * r * p) >> 16);
    endfunction

    function automatic t_reply predict_lease(t_action act, logic [15:0] rid,
                                             logic [39:0] t);
        t_reply      rep;
        logic [63:0] len;
        int          s;
        int          fs;
        rep = '0;
        case (act)
            ACT_ALLOC: begin
                if (m_last >= m_first) begin
                    expire_leases(t);
                    len = grant_length(t);
                    for (int id = int'(m_first); id <= int'(m_last); id++) begin
                        if (slot_of(id[15:0]) < 0) begin
                            fs = -1;
                            for (int i = ENT - 1; i >= 0; i--)
                                if (!m_valid[i]) fs = i;
                            if (fs >= 0) begin
                                m_valid[fs] = 1'b1;
                                m_id[fs] = id[15:0];
                                m_exp[fs] = sat_end(t, len);
                                if (m_wcount < 64'hFFFF_FFFF) m_wcount++;
                                rep.ok = 1'b1;
                                rep.gid = id[15:0];
                                rep.lend = m_exp[fs][39:0];
                            end
                            break;
                        end
                    end
                end
            end
            ACT_RELEASE: begin
                s = slot_of(rid);
                if (s >= 0) begin
                    m_valid[s] = 1'b0;
                    rep.ok = 1'b1;
                end
            end
            ACT_TOUCH: begin
                s = slot_of(rid);
                if (s >= 0) begin
                    len = clamp_len((m_def * ((m_pol >> 28) & 64'hFFF)) >> 8);
                    m_exp[s] = sat_end(t, len);
                    rep.ok = 1'b1;
                    rep.lend = m_exp[s][39:0];
                end
            end
            default: begin
                expire_leases(t);
                rep.ok = 1'b1;
            end
        endcase
        return rep;
    endfunction

    task automatic send_request(t_action act, logic [15:0] rid, logic [39:0] t);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_req_id   <= rid;
        i_now      <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_replies.push_back(predict_lease(act, rid, t));
        items_sent++;
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [39:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_FIRST_ID:  m_first = val[15:0];
            CFG_LAST_ID:   m_last  = val[15:0];
            CFG_DEFAULT:   m_def   = val[31:0];
            CFG_MIN:       m_min   = val[31:0];
            CFG_MAX:       m_max   = val[31:0];
            CFG_WINDOW:    m_win   = val[31:0];
            CFG_THRESHOLD: m_thr   = val[19:0];
            default:       m_pol   = val;
        endcase
    endtask

    function automatic logic [39:0] policy_word(bit en, int rf, int wm, int pf, int tf);
        return {tf[11:0], pf[8:0], wm[8:0], rf[8:0], en};
    endfunction

    task automatic set_policy(logic [15:0] lo, logic [15:0] hi, logic [31:0] dl,
                              logic [31:0] mn, logic [31:0] mx, logic [31:0] wn,
                              logic [19:0] th, logic [39:0] pol);
        drain_replies();
        write_reg(CFG_FIRST_ID, 40'(lo));
        write_reg(CFG_LAST_ID, 40'(hi));
        write_reg(CFG_DEFAULT, 40'(dl));
        write_reg(CFG_MIN, 40'(mn));
        write_reg(CFG_MAX, 40'(mx));
        write_reg(CFG_WINDOW, 40'(wn));
        write_reg(CFG_THRESHOLD, 40'(th));
        write_reg(CFG_POLICY, pol);
    endtask

    task automatic test_reset_defaults();
        send_request(ACT_ALLOC, 16'd0, 40'd100);
        send_request(ACT_ALLOC, 16'hFFFF, 40'd100);
        send_request(ACT_ALLOC, 16'd0, 40'd101);
        send_request(ACT_RELEASE, 16'd1, 40'd0);
        send_request(ACT_RELEASE, 16'd300, 40'd0);
        send_request(ACT_ALLOC, 16'd0, 40'd102);
        send_request(ACT_TOUCH, 16'd0, 40'd200);
        send_request(ACT_TOUCH, 16'hFFFF, 40'd200);
        send_request(ACT_CLEAN, 16'd0, 40'd1_000_000);
    endtask

    task automatic test_empty_pool();
        set_policy(16'd5, 16'd4, 32'd100, 32'd10, 32'd1000, 32'd3600, 20'd60, RST_POLICY);
        send_request(ACT_ALLOC, 16'd5, 40'd50);
    endtask

    task automatic test_top_ids_saturate();
        set_policy(16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 20'hFFFFF, policy_word(1, 511, 511, 511, 12'hFFF));
        send_request(ACT_ALLOC, 16'd0, 40'hFF_FFFF_FF00);
        send_request(ACT_ALLOC, 16'd0, 40'hFF_FFFF_FF00);
        send_request(ACT_ALLOC, 16'd0, 40'hFF_FFFF_FF00);
        send_request(ACT_TOUCH, 16'hFFFF, 40'hFF_FFFF_FFFF);
        send_request(ACT_CLEAN, 16'd0, 40'hFF_FFFF_FFFF);
    endtask

    task automatic test_zero_factors();
        set_policy(16'd0, 16'd3, 32'd500, 32'd900, 32'd20, 32'd1, 20'd1,
                   policy_word(1, 0, 0, 0, 0));
        send_request(ACT_ALLOC, 16'd0, 40'd0);
        send_request(ACT_ALLOC, 16'd0, 40'd7);
        send_request(ACT_TOUCH, 16'd1, 40'd8);
        send_request(ACT_RELEASE, 16'd0, 40'hFF_FFFF_FFFF);
    endtask

    task automatic test_pause_until_empty();
        send_request(ACT_ALLOC, 16'd0, 40'd30);
        send_request(ACT_CLEAN, 16'd0, 40'd31);
        drain_replies();
        send_request(ACT_ALLOC, 16'd0, 40'd32);
    endtask

    task automatic random_phase(int n);
        int          pick;
        int          s;
        logic [15:0] rid;
        logic [39:0] t;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            s = $urandom_range(0, ENT - 1);
            rid = m_valid[s] ? m_id[s] : 16'(m_first + $urandom_range(0, 3));
            clock_now = clock_now + $urandom_range(0, 40);
            t = clock_now;
            if (pick < 45)      send_request(ACT_ALLOC, 16'($urandom), t);
            else if (pick < 65) send_request(ACT_RELEASE, rid, t);
            else if (pick < 85) send_request(ACT_TOUCH, rid, t);
            else if (pick < 93) send_request(ACT_CLEAN, 16'($urandom), t);
            else send_request(t_action'($urandom_range(0, 3)), 16'($urandom),
                              40'({$urandom, $urandom}));
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0] lo;
        for (int ph = 0; ph < 8; ph++) begin
            lo = (ph % 3 == 0) ? 16'd0 : 16'($urandom_range(0, 65535 - 100));
            if (ph == 7) no_idle = 1'b1;
            set_policy(lo, lo + 16'($urandom_range(0, 90)), $urandom_range(20, 600),
                       $urandom_range(1, 200), $urandom_range(100, 800),
                       (ph % 2) ? 32'hFFFF_FFFF : $urandom_range(1, 300),
                       20'($urandom_range(1, 2000)),
                       40'({$urandom, $urandom}));
            random_phase(100);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_ok, o_granted_id, o_lease_end};
                if (pending_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected beat: %p", seen);
                end else begin
                    want = pending_replies.pop_front();
                    if (want.ok) grants += (want.gid != 0 || want.lend != 0);
                    if (seen !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: want ok=%0d id=%0d end=%0d ",
                                      "got ok=%0d id=%0d end=%0d"},
                                     want.ok, want.gid, want.lend,
                                     seen.ok, seen.gid, seen.lend);
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("watchdog expired");
                $display("tb_adaptive_id_lease_allocator: errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_ALLOC;
        i_req_id    <= '0;
        i_now       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FIRST_ID;
        i_cfg_data  <= '0;
        m_first = RST_FIRST_ID;
        m_last = RST_LAST_ID;
        m_def = RST_DEFAULT;
        m_min = RST_MIN;
        m_max = RST_MAX;
        m_win = RST_WINDOW;
        m_thr = RST_THRESHOLD;
        m_pol = RST_POLICY;
        m_wstart = 0;
        m_wcount = 0;
        for (int i = 0; i < ENT; i++) begin
            m_valid[i] = 1'b0;
            m_id[i] = '0;
            m_exp[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_empty_pool();
        test_top_ids_saturate();
        test_zero_factors();
        test_pause_until_empty();
        test_random_traffic();
        drain_replies();
        repeat (100) @(posedge i_clk);
        $display("covered %0d requests over %0d register writes,", items_sent, cfg_writes);
        $display("%0d beats with grant or renewal", grants);
        if (errors == 0)
            $display("tb_adaptive_id_lease_allocator: clean");
        else
            $display("tb_adaptive_id_lease_allocator: errors");
        $finish;
    end
endmodule

>>> files.f
src/ail_pkg.sv
src/ail_ctrl.sv
src/ail_dp.sv
src/adaptive_id_lease_allocator.sv
src/ail_checker.sv
verif/tb_adaptive_id_lease_allocator.sv
